FILE: rtl/ell_pkg.sv
// Shared types, token codes and keyword lookup for the expression lexer
package ell_pkg;

    localparam logic [5:0] TK_NUMBER   = 6'd0;
    localparam logic [5:0] TK_PRINT    = 6'd1;
    localparam logic [5:0] TK_READ     = 6'd2;
    localparam logic [5:0] TK_AND      = 6'd3;
    localparam logic [5:0] TK_OR       = 6'd4;
    localparam logic [5:0] TK_IF       = 6'd5;
    localparam logic [5:0] TK_THEN     = 6'd6;
    localparam logic [5:0] TK_ELSE     = 6'd7;
    localparam logic [5:0] TK_WHILE    = 6'd8;
    localparam logic [5:0] TK_DO       = 6'd9;
    localparam logic [5:0] TK_DONE     = 6'd10;
    localparam logic [5:0] TK_FUNCTION = 6'd11;
    localparam logic [5:0] TK_VARIABLE = 6'd12;
    localparam logic [5:0] TK_PLUS     = 6'd13;
    localparam logic [5:0] TK_MINUS    = 6'd14;
    localparam logic [5:0] TK_STAR     = 6'd15;
    localparam logic [5:0] TK_SLASH    = 6'd16;
    localparam logic [5:0] TK_PERCENT  = 6'd17;
    localparam logic [5:0] TK_LBRACK   = 6'd18;
    localparam logic [5:0] TK_RBRACK   = 6'd19;
    localparam logic [5:0] TK_LPAREN   = 6'd20;
    localparam logic [5:0] TK_RPAREN   = 6'd21;
    localparam logic [5:0] TK_QUEST    = 6'd22;
    localparam logic [5:0] TK_COLON    = 6'd23;
    localparam logic [5:0] TK_ASSIGN   = 6'd24;
    localparam logic [5:0] TK_EQ       = 6'd25;
    localparam logic [5:0] TK_NOT      = 6'd26;
    localparam logic [5:0] TK_NE       = 6'd27;
    localparam logic [5:0] TK_GT       = 6'd28;
    localparam logic [5:0] TK_GE       = 6'd29;
    localparam logic [5:0] TK_LT       = 6'd30;
    localparam logic [5:0] TK_LE       = 6'd31;
    localparam logic [5:0] TK_EOL      = 6'd32;
    localparam logic [5:0] TK_EOF      = 6'd33;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_BAD_FUNC = 2'd2;
    localparam logic [1:0] ERR_BAD_VAR  = 2'd3;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_source;
    } in_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  error_code;
        logic [20:0] line_number;
        logic [63:0] number_value;
        logic        number_overflow;
        logic [19:0] name_start;
        logic [20:0] name_length;
        logic        last_result;
    } out_t;

    typedef struct packed {
        logic [20:0] line;
        logic [5:0]  kind0;
        logic [1:0]  err0;
        logic [63:0] value;
        logic        ovf;
        logic [19:0] start;
        logic [20:0] len;
        logic [5:0]  kind1;
        logic [1:0]  err1;
        logic [5:0]  kind2;
        logic [1:0]  err2;
        logic [1:0]  cnt;
    } bundle_t;

    function automatic logic [5:0] kw_kind(logic [39:0] p, logic [20:0] n);
        logic [5:0] k;
        k = TK_NUMBER;
        if (n == 21'd5 && p == 40'h7072696e74) k = TK_PRINT;
        if (n == 21'd4 && p == 40'h0072656164) k = TK_READ;
        if (n == 21'd3 && p == 40'h0000616e64) k = TK_AND;
        if (n == 21'd2 && p == 40'h0000006f72) k = TK_OR;
        if (n == 21'd2 && p == 40'h0000006966) k = TK_IF;
        if (n == 21'd4 && p == 40'h007468656e) k = TK_THEN;
        if (n == 21'd4 && p == 40'h00656c7365) k = TK_ELSE;
        if (n == 21'd5 && p == 40'h7768696c65) k = TK_WHILE;
        if (n == 21'd2 && p == 40'h000000646f) k = TK_DO;
        if (n == 21'd4 && p == 40'h00646f6e65) k = TK_DONE;
        return k;
    endfunction

endpackage

FILE: rtl/ell_front.sv
// Scanner front: consumes one byte per transfer and builds result bundles
module ell_front #(
    parameter int NUMBER_WIDTH = 64,
    parameter logic [20:0] CAP = 21'd1048576
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ell_pkg::in_t     in_data,
    input  logic             q_full,
    output logic             q_push,
    output ell_pkg::bundle_t q_data
);
    typedef enum logic [3:0] {
        M_IDLE, M_NUM, M_WORD, M_SLASH, M_EQ, M_BANG, M_GT, M_LT,
        M_LINECOM, M_BLOCK, M_BLOCKSTAR
    } mode_t;

    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LBR   = 8'h5b;
    localparam logic [7:0] CH_RBR   = 8'h5d;
    localparam logic [7:0] CH_LPA   = 8'h28;
    localparam logic [7:0] CH_RPA   = 8'h29;
    localparam logic [7:0] CH_QST   = 8'h3f;
    localparam logic [7:0] CH_COL   = 8'h3a;

    localparam int NW = NUMBER_WIDTH;

    mode_t           mode_reg, mode_next;
    logic [39:0]     prefix_reg, prefix_next;
    logic [20:0]     wlen_reg, wlen_next;
    logic [2:0]      flags_reg, flags_next;
    logic [NW-1:0]   acc_reg, acc_next;
    logic            ovf_reg, ovf_next;
    logic [20:0]     line_reg, line_next;
    logic [20:0]     pos_reg, pos_next;
    logic [19:0]     tstart_reg, tstart_next;
    logic            err_reg, err_next;

    logic [7:0]      c;
    logic            is_dig, is_up, is_lo;
    logic [NW+3:0]   acc_ext;
    logic [5:0]      kw;
    logic            fl_error;
    logic [5:0]      fl_kind;
    logic [1:0]      fl_err;
    logic            fl_pend;
    logic            id_emit;
    logic [5:0]      id_kind;
    logic [1:0]      id_err;
    logic            do_flush, do_idle, line_inc;
    logic            take;
    ell_pkg::bundle_t b;

    assign c      = in_data.char_byte;
    assign is_dig = c >= CH_ZERO && c <= 8'h39;
    assign is_up  = c >= 8'h41 && c <= 8'h5a;
    assign is_lo  = c >= 8'h61 && c <= 8'h7a;
    assign acc_ext = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                   + (NW+4)'(c - CH_ZERO);
    assign kw = ell_pkg::kw_kind(prefix_reg, wlen_reg);
    assign take = in_valid && in_ready;
    assign in_ready = !q_full;

    always_comb
    begin
        fl_error = 1'b0;
        fl_err   = ell_pkg::ERR_NONE;
        fl_pend  = 1'b1;
        fl_kind  = ell_pkg::TK_NUMBER;
        unique case (mode_reg)
            M_NUM:   fl_kind = ell_pkg::TK_NUMBER;
            M_WORD:
            begin
                if (kw != ell_pkg::TK_NUMBER)
                    fl_kind = kw;
                else if (flags_reg[0])
                begin
                    fl_kind = ell_pkg::TK_FUNCTION;
                    if (flags_reg[2])
                    begin
                        fl_error = 1'b1;
                        fl_err   = ell_pkg::ERR_BAD_FUNC;
                    end
                end
                else
                begin
                    fl_kind = ell_pkg::TK_VARIABLE;
                    if (flags_reg[1])
                    begin
                        fl_error = 1'b1;
                        fl_err   = ell_pkg::ERR_BAD_VAR;
                    end
                end
            end
            M_SLASH: fl_kind = ell_pkg::TK_SLASH;
            M_EQ:    fl_kind = ell_pkg::TK_ASSIGN;
            M_BANG:  fl_kind = ell_pkg::TK_NOT;
            M_GT:    fl_kind = ell_pkg::TK_GT;
            M_LT:    fl_kind = ell_pkg::TK_LT;
            default: fl_pend = 1'b0;
        endcase
        if (fl_error)
            fl_kind = ell_pkg::TK_NUMBER;
    end

    always_comb
    begin
        id_emit = 1'b1;
        id_err  = ell_pkg::ERR_NONE;
        id_kind = ell_pkg::TK_NUMBER;
        if (is_dig || is_up || is_lo)
            id_emit = 1'b0;
        else
        begin
            priority case (c)
                CH_NUL, CH_SP, CH_TAB, CH_CR,
                CH_SLASH, CH_EQ, CH_BANG, CH_GT, CH_LT: id_emit = 1'b0;
                CH_PLUS:  id_kind = ell_pkg::TK_PLUS;
                CH_MINUS: id_kind = ell_pkg::TK_MINUS;
                CH_STAR:  id_kind = ell_pkg::TK_STAR;
                CH_PCT:   id_kind = ell_pkg::TK_PERCENT;
                CH_LBR:   id_kind = ell_pkg::TK_LBRACK;
                CH_RBR:   id_kind = ell_pkg::TK_RBRACK;
                CH_LPA:   id_kind = ell_pkg::TK_LPAREN;
                CH_RPA:   id_kind = ell_pkg::TK_RPAREN;
                CH_QST:   id_kind = ell_pkg::TK_QUEST;
                CH_COL:   id_kind = ell_pkg::TK_COLON;
                CH_NL:    id_kind = ell_pkg::TK_EOL;
                default:  id_err  = ell_pkg::ERR_INVALID;
            endcase
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        wlen_next   = wlen_reg;
        flags_next  = flags_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        line_next   = line_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        err_next    = err_reg;
        do_flush    = 1'b0;
        do_idle     = 1'b0;
        line_inc    = 1'b0;

        b = '0;
        b.line = line_reg;

        if (in_data.end_of_source)
        begin
            if (!err_reg && fl_pend)
            begin
                b.kind0 = fl_kind;
                b.err0  = fl_err;
                if (mode_reg == M_NUM)
                begin
                    b.value = 64'(acc_reg);
                    b.ovf   = ovf_reg;
                end
                if (mode_reg == M_WORD && !fl_error && kw == ell_pkg::TK_NUMBER)
                begin
                    b.start = tstart_reg;
                    b.len   = wlen_reg;
                end
                b.kind1 = ell_pkg::TK_EOL;
                b.kind2 = ell_pkg::TK_EOF;
                b.cnt   = 2'd3;
            end
            else
            begin
                b.kind0 = ell_pkg::TK_EOL;
                b.kind1 = ell_pkg::TK_EOF;
                b.cnt   = 2'd2;
            end
            mode_next   = M_IDLE;
            prefix_next = '0;
            wlen_next   = '0;
            flags_next  = '0;
            acc_next    = '0;
            ovf_next    = 1'b0;
            line_next   = 21'd1;
            pos_next    = '0;
            tstart_next = '0;
            err_next    = 1'b0;
        end
        else if (!err_reg)
        begin
            if (pos_reg < CAP)
                pos_next = pos_reg + 21'd1;
            unique case (mode_reg)
                M_NUM:
                    if (is_dig)
                    begin
                        if (acc_ext[NW+3:NW] != 4'd0)
                        begin
                            acc_next = '1;
                            ovf_next = 1'b1;
                        end
                        else
                            acc_next = acc_ext[NW-1:0];
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                M_WORD:
                    if (is_dig || is_up || is_lo)
                    begin
                        if (wlen_reg < 21'd5)
                            prefix_next = {prefix_reg[31:0], c};
                        if (wlen_reg < CAP)
                            wlen_next = wlen_reg + 21'd1;
                        if (is_up)
                            flags_next[1] = 1'b1;
                        else
                            flags_next[2] = 1'b1;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_idle  = !fl_error;
                    end
                M_SLASH:
                    if (c == CH_SLASH)
                        mode_next = M_LINECOM;
                    else if (c == CH_STAR)
                        mode_next = M_BLOCKSTAR;
                    else
                    begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                M_EQ, M_BANG, M_GT, M_LT:
                    if (c == CH_EQ)
                    begin
                        b.kind0   = fl_kind + 6'd1;
                        b.cnt     = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_idle  = 1'b1;
                    end
                M_LINECOM:
                    if (c == CH_NL)
                        do_idle = 1'b1;
                M_BLOCK:
                    if (c == CH_STAR)
                        mode_next = M_BLOCKSTAR;
                    else if (c == CH_NL)
                        line_inc = 1'b1;
                M_BLOCKSTAR:
                    if (c == CH_SLASH)
                        mode_next = M_IDLE;
                    else if (c != CH_STAR)
                    begin
                        line_inc  = c == CH_NL;
                        mode_next = M_BLOCK;
                    end
                default: do_idle = 1'b1;
            endcase

            if (do_flush)
            begin
                b.kind0 = fl_kind;
                b.err0  = fl_err;
                if (mode_reg == M_NUM)
                begin
                    b.value = 64'(acc_reg);
                    b.ovf   = ovf_reg;
                end
                if (mode_reg == M_WORD && !fl_error && kw == ell_pkg::TK_NUMBER)
                begin
                    b.start = tstart_reg;
                    b.len   = wlen_reg;
                end
                b.cnt     = 2'd1;
                mode_next = M_IDLE;
                if (fl_error)
                    err_next = 1'b1;
            end

            if (do_idle)
            begin
                mode_next = M_IDLE;
                if (id_emit)
                begin
                    if (do_flush)
                    begin
                        b.kind1 = id_kind;
                        b.err1  = id_err;
                        b.cnt   = 2'd2;
                    end
                    else
                    begin
                        b.kind0 = id_kind;
                        b.err0  = id_err;
                        b.cnt   = 2'd1;
                    end
                    if (id_err != ell_pkg::ERR_NONE)
                        err_next = 1'b1;
                    if (c == CH_NL)
                        line_inc = 1'b1;
                end
                if (is_dig)
                begin
                    mode_next = M_NUM;
                    acc_next  = NW'(c - CH_ZERO);
                    ovf_next  = 1'b0;
                end
                else if (is_up || is_lo)
                begin
                    mode_next   = M_WORD;
                    prefix_next = {32'd0, c};
                    wlen_next   = 21'd1;
                    flags_next  = is_up ? 3'b011 : 3'b100;
                    tstart_next = pos_reg < CAP ? pos_reg[19:0] : 20'(CAP - 21'd1);
                end
                else
                begin
                    priority case (c)
                        CH_SLASH: mode_next = M_SLASH;
                        CH_EQ:    mode_next = M_EQ;
                        CH_BANG:  mode_next = M_BANG;
                        CH_GT:    mode_next = M_GT;
                        CH_LT:    mode_next = M_LT;
                        default:  mode_next = M_IDLE;
                    endcase
                end
            end

            if (line_inc && line_reg < CAP)
                line_next = line_reg + 21'd1;
        end
    end

    assign q_push = take && b.cnt != 2'd0;
    assign q_data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            prefix_reg <= '0;
            wlen_reg   <= '0;
            flags_reg  <= '0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
            line_reg   <= 21'd1;
            pos_reg    <= '0;
            tstart_reg <= '0;
            err_reg    <= 1'b0;
        end
        else if (take)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            wlen_reg   <= wlen_next;
            flags_reg  <= flags_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            err_reg    <= err_next;
        end
    end
endmodule

FILE: rtl/ell_fifo.sv
// Two-entry bundle queue between scanner and result sequencer
module ell_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ell_pkg::bundle_t wr_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output ell_pkg::bundle_t rd_data
);
    ell_pkg::bundle_t mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end
endmodule

FILE: rtl/ell_back.sv
// Result sequencer: unpacks each bundle into single result transfers
module ell_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  ell_pkg::bundle_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output ell_pkg::out_t    out_data
);
    logic [1:0] idx_reg;
    logic       last;

    assign out_valid = !q_empty;
    assign last      = idx_reg == q_data.cnt - 2'd1;
    assign q_pop     = out_valid && out_ready && last;

    always_comb
    begin
        out_data             = '0;
        out_data.line_number = q_data.line;
        out_data.last_result = last;
        unique case (idx_reg)
            2'd0:
            begin
                out_data.token_kind      = q_data.kind0;
                out_data.error_code      = q_data.err0;
                out_data.number_value    = q_data.value;
                out_data.number_overflow = q_data.ovf;
                out_data.name_start      = q_data.start;
                out_data.name_length     = q_data.len;
            end
            2'd1:
            begin
                out_data.token_kind = q_data.kind1;
                out_data.error_code = q_data.err1;
            end
            default:
            begin
                out_data.token_kind = q_data.kind2;
                out_data.error_code = q_data.err2;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (out_valid && out_ready)
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
    end
endmodule

FILE: rtl/expression_language_lexer_unit.sv
// Top level of the streaming expression lexer
//
//   channel | direction | payload         | transfer
//   in      | sink      | ell_pkg::in_t   | in_valid & in_ready
//   out     | source    | ell_pkg::out_t  | out_valid & out_ready
//
// One byte is taken per cycle while the two-entry bundle queue has room.
// Each byte yields zero to three results; with out_ready high the sequencer
// sends one per cycle, giving one byte per cycle when each gives at most one.
// Reset clears scanner state, queue pointers and sequencer index.
// A stall on out fills the queue, then drops in_ready.
module expression_language_lexer_unit #(
    parameter longint unsigned MAX_SOURCE_BYTES = 64'd1048576,
    parameter int              NUMBER_WIDTH     = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ell_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ell_pkg::out_t out_data
);
    localparam logic [20:0] CAP = (MAX_SOURCE_BYTES > 64'd1048576) ?
                                  21'd1048576 : 21'(MAX_SOURCE_BYTES);

    logic             q_full, q_empty, q_push, q_pop;
    ell_pkg::bundle_t q_wr, q_rd;

    ell_front #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .CAP          (CAP)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr)
    );

    ell_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (q_rd)
    );

    ell_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule
